>>> sv/nucleotide_2bit_packer_assert.svh
// Assertion macros for the nucleotide 2-bit packer.
`ifndef NUCLEOTIDE_2BIT_PACKER_ASSERT_SVH
`define NUCLEOTIDE_2BIT_PACKER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define N2B_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define N2B_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define N2B_ASSERT(lbl, clk, rst, prop, msg)
`define N2B_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> sv/n2b_pkg.sv
// Types, constants and helper functions for the nucleotide 2-bit packer.
`default_nettype none
package n2b_pkg;

   localparam int POSITION_BITS_DEF = 40;
   localparam int LEN_W       = 31;
   localparam int HBASE_W     = 32;
   localparam int POS_OUT_W   = 40;
   localparam int BYTE_W      = 8;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 152;

   typedef enum logic [1:0] {
      OP_CHAR   = 2'd0,
      OP_END    = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_PACKED = 2'd0,
      KIND_HOLE   = 2'd1,
      KIND_SEQ    = 2'd2,
      KIND_TAIL   = 2'd3
   } kind_type;

   typedef struct packed {
      logic       known;
      logic [1:0] code;
   } base_type;

   // A/C/G/T in either case; anything else packs as G
   function automatic base_type base_code(input logic [BYTE_W-1:0] s);
      base_type b;
      b.known = 1'b1;
      b.code  = 2'd2;
      case (s) inside
         8'h41, 8'h61: b.code = 2'd0;
         8'h43, 8'h63: b.code = 2'd1;
         8'h47, 8'h67: b.code = 2'd2;
         8'h54, 8'h74: b.code = 2'd3;
         default:      b.known = 1'b0;
      endcase
      return b;
   endfunction

   function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage
`default_nettype wire

>>> sv/nucleotide_2bit_packer.sv
// Nucleotide 2-bit packer: base packing, hole records and sequence records.
// Flow: an accepted item is held in the input register until it is processed; its
//   results are registered in the pending slots and then driven on rsp_.
// Throughput: one item per cycle while results are taken and items give at most one
//   result each; an item with more (up to four) holds the result port, one per cycle.
// Reset: synchronous, active high; clears all counters, the pack byte and pending results.
`default_nettype none
`include "nucleotide_2bit_packer_assert.svh"
module nucleotide_2bit_packer #(
   parameter int POSITION_BITS = n2b_pkg::POSITION_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [n2b_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [7:0] symbol
   input  wire  [1:0]                       req_tuser,  // [1:0] opcode
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [7:0] byte_value, [47:8] position, [78:48] run_length, [86:79] hole_char,
   // [118:87] hole_base, [149:119] hole_count, [151:150] zero
   output logic [n2b_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [1:0]                       rsp_tuser,  // [1:0] kind
   output logic                             rsp_tlast
);
   import n2b_pkg::*;

   localparam int PW = POSITION_BITS;

   // input register
   logic                 in_vld_ff, in_vld_in;
   op_type               in_op_ff;
   logic [BYTE_W-1:0]    in_sym_ff;

   // pending result slots, emitted lowest first:
   // bit 0 hole record, bit 1 sequence record, bit 2 byte, bit 3 count byte
   logic [3:0]           pend_ff, pend_in;
   logic [PW-1:0]        hrec_pos_ff;
   logic [LEN_W-1:0]     hrec_len_ff;
   logic [BYTE_W-1:0]    hrec_chr_ff;
   logic [PW-1:0]        srec_pos_ff;
   logic [LEN_W-1:0]     srec_len_ff;
   logic [HBASE_W-1:0]   srec_base_ff;
   logic [LEN_W-1:0]     srec_cnt_ff;
   kind_type             brec_kind_ff, brec_kind_in;
   logic [BYTE_W-1:0]    brec_val_ff, brec_val_in;
   logic [1:0]           crec_val_ff;

   // packer state
   logic [BYTE_W-1:0]    acc_ff, acc_in;
   logic [1:0]           fill_ff, fill_in;
   logic [PW-1:0]        total_ff, total_in;
   logic [PW-1:0]        seq_start_ff, seq_start_in;
   logic [LEN_W-1:0]     seq_len_ff, seq_len_in;
   logic                 hole_open_ff, hole_open_in;
   logic [PW-1:0]        hole_start_ff, hole_start_in;
   logic [LEN_W-1:0]     hole_len_ff, hole_len_in;
   logic [BYTE_W-1:0]    hole_sym_ff, hole_sym_in;
   logic [LEN_W-1:0]     his_ff, his_in;      // holes in current sequence
   logic [HBASE_W-1:0]   htot_ff, htot_in;    // holes overall

   logic                 proc_fire, rsp_fire, pend_single;
   logic [3:0]           pend_drain;
   base_type             bc;
   logic                 cont;
   logic [BYTE_W-1:0]    acc_or;

   // An item is processed when the slots are empty or their last result leaves now
   assign pend_single = (pend_ff & (pend_ff - 4'd1)) == 4'd0;
   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign proc_fire   = in_vld_ff && ((pend_ff == 4'd0) || (rsp_tready && pend_single));
   assign req_tready  = !in_vld_ff || proc_fire;
   assign pend_drain  = pend_ff & (pend_ff - 4'd1);

   assign bc     = base_code(in_sym_ff);
   assign cont   = hole_open_ff && !bc.known && (in_sym_ff == hole_sym_ff);
   assign acc_or = acc_ff | (BYTE_W'(bc.code) << {~fill_ff, 1'b0});

   always_comb begin
      in_vld_in     = in_vld_ff;
      pend_in       = rsp_fire ? pend_drain : pend_ff;
      brec_kind_in  = brec_kind_ff;
      brec_val_in   = brec_val_ff;
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      seq_start_in  = seq_start_ff;
      seq_len_in    = seq_len_ff;
      hole_open_in  = hole_open_ff;
      hole_start_in = hole_start_ff;
      hole_len_in   = hole_len_ff;
      hole_sym_in   = hole_sym_ff;
      his_in        = his_ff;
      htot_in       = htot_ff;

      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (proc_fire) begin
         in_vld_in = 1'b0;
      end

      if (proc_fire) begin
         pend_in = 4'b0000;
         unique case (in_op_ff)
            OP_CHAR: begin
               if (!cont && hole_open_ff) begin
                  pend_in[0] = 1'b1;
               end
               if (cont) begin
                  hole_len_in = sat_inc(hole_len_ff);
               end else if (!bc.known) begin
                  hole_open_in  = 1'b1;
                  hole_start_in = total_ff;
                  hole_len_in   = LEN_W'(1);
                  hole_sym_in   = in_sym_ff;
                  his_in        = sat_inc(his_ff);
                  htot_in       = htot_ff + 1'b1;
               end else begin
                  hole_open_in = 1'b0;
               end
               brec_kind_in = KIND_PACKED;
               brec_val_in  = acc_or;
               if (fill_ff == 2'd3) begin
                  pend_in[2] = 1'b1;
                  acc_in     = '0;
               end else begin
                  acc_in = acc_or;
               end
               fill_in    = fill_ff + 2'd1;
               total_in   = total_ff + 1'b1;
               seq_len_in = sat_inc(seq_len_ff);
            end
            OP_END: begin
               pend_in[0]   = hole_open_ff;
               pend_in[1]   = 1'b1;
               hole_open_in = 1'b0;
               seq_start_in = total_ff;
               seq_len_in   = '0;
               his_in       = '0;
            end
            OP_FINISH: begin
               if (seq_len_ff != '0 || hole_open_ff) begin
                  pend_in[0] = hole_open_ff;
                  pend_in[1] = 1'b1;
               end
               pend_in[2] = 1'b1;
               pend_in[3] = 1'b1;
               if (fill_ff != 2'd0) begin
                  brec_kind_in = KIND_PACKED;
                  brec_val_in  = acc_ff;
               end else begin
                  brec_kind_in = KIND_TAIL;
                  brec_val_in  = '0;
               end
               // whole stream state back to reset
               acc_in        = '0;
               fill_in       = '0;
               total_in      = '0;
               seq_start_in  = '0;
               seq_len_in    = '0;
               hole_open_in  = 1'b0;
               hole_start_in = '0;
               hole_len_in   = '0;
               hole_sym_in   = '0;
               his_in        = '0;
               htot_in       = '0;
            end
            OP_NONE: begin
               pend_in = 4'b0000;
            end
            default: begin
               pend_in = 4'b0000;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         pend_ff       <= 4'b0000;
         acc_ff        <= '0;
         fill_ff       <= '0;
         total_ff      <= '0;
         seq_start_ff  <= '0;
         seq_len_ff    <= '0;
         hole_open_ff  <= 1'b0;
         hole_start_ff <= '0;
         hole_len_ff   <= '0;
         hole_sym_ff   <= '0;
         his_ff        <= '0;
         htot_ff       <= '0;
      end else begin
         in_vld_ff     <= in_vld_in;
         pend_ff       <= pend_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         total_ff      <= total_in;
         seq_start_ff  <= seq_start_in;
         seq_len_ff    <= seq_len_in;
         hole_open_ff  <= hole_open_in;
         hole_start_ff <= hole_start_in;
         hole_len_ff   <= hole_len_in;
         hole_sym_ff   <= hole_sym_in;
         his_ff        <= his_in;
         htot_ff       <= htot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= op_type'(req_tuser);
         in_sym_ff <= req_tdata[BYTE_W-1:0];
      end
      if (proc_fire) begin
         // records take the state as it stood before this item
         hrec_pos_ff  <= hole_start_ff;
         hrec_len_ff  <= hole_len_ff;
         hrec_chr_ff  <= hole_sym_ff;
         srec_pos_ff  <= seq_start_ff;
         srec_len_ff  <= seq_len_ff;
         srec_base_ff <= htot_ff - HBASE_W'(his_ff);
         srec_cnt_ff  <= his_ff;
         brec_kind_ff <= brec_kind_in;
         brec_val_ff  <= brec_val_in;
         crec_val_ff  <= total_ff[1:0];
      end
   end

   // result selection: lowest pending slot goes out first
   always_comb begin
      rsp_tvalid = pend_ff != 4'b0000;
      rsp_tlast  = pend_single;
      rsp_tuser  = KIND_TAIL;
      rsp_tdata  = '0;
      if (pend_ff[0]) begin
         rsp_tuser        = KIND_HOLE;
         rsp_tdata[47:8]  = POS_OUT_W'(hrec_pos_ff);
         rsp_tdata[78:48] = hrec_len_ff;
         rsp_tdata[86:79] = hrec_chr_ff;
      end else if (pend_ff[1]) begin
         rsp_tuser          = KIND_SEQ;
         rsp_tdata[47:8]    = POS_OUT_W'(srec_pos_ff);
         rsp_tdata[78:48]   = srec_len_ff;
         rsp_tdata[118:87]  = srec_base_ff;
         rsp_tdata[149:119] = srec_cnt_ff;
      end else if (pend_ff[2]) begin
         rsp_tuser      = brec_kind_ff;
         rsp_tdata[7:0] = brec_val_ff;
      end else begin
         rsp_tuser      = KIND_TAIL;
         rsp_tdata[7:0] = BYTE_W'(crec_val_ff);
      end
   end

   // checks
   `N2B_ASSERT(a_last_drains, clock, reset, rsp_fire && rsp_tlast && !proc_fire |=> !rsp_tvalid, "slots not empty after last result")
   `N2B_NEVER(a_proc_overrun, clock, reset, proc_fire && !pend_single, "item processed over pending results")
   `N2B_ASSERT(a_finish_clears, clock, reset, proc_fire && in_op_ff == OP_FINISH |=> total_ff == '0 && fill_ff == 2'd0 && !hole_open_ff, "finish left stream state")
   `N2B_NEVER(a_hole_in_seq, clock, reset, hole_open_ff && seq_len_ff == '0, "open hole in empty sequence")

endmodule
`default_nettype wire
